>>> sv/frr_pkg.sv
// Package: shared constants and types for the framed record receiver.
`timescale 1ns / 1ps

package frr_pkg;

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_BYTE   = 8'h03;
    localparam logic [7:0] MAX_ID     = 8'd62;

    localparam int BODY_LEN   = 10;
    localparam int BODY_IDX_W = $clog2(BODY_LEN);

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_SEQ   = 5'b00010,
        PH_BODY  = 5'b00100,
        PH_CHECK = 5'b01000,
        PH_END   = 5'b10000
    } frr_phase_t;

    typedef struct packed {
        logic [5:0] record_id;
        logic [7:0] data_high;
        logic [7:0] data_low;
        logic [7:0] wave_0;
        logic [7:0] wave_1;
        logic [7:0] wave_2;
        logic [7:0] wave_3;
        logic [7:0] wave_4;
        logic [7:0] wave_5;
        logic [7:0] wave_6;
        logic [7:0] wave_7;
    } frr_record_t;

endpackage

>>> sv/frr_if.sv
// Interfaces: received byte channel and decoded record channel.
`timescale 1ns / 1ps

interface frr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frr_record_if;
    logic       valid;
    logic       ready;
    logic [5:0] record_id;
    logic [7:0] data_high;
    logic [7:0] data_low;
    logic [7:0] wave_0;
    logic [7:0] wave_1;
    logic [7:0] wave_2;
    logic [7:0] wave_3;
    logic [7:0] wave_4;
    logic [7:0] wave_5;
    logic [7:0] wave_6;
    logic [7:0] wave_7;

    modport source (
        output valid, output record_id, output data_high, output data_low,
        output wave_0, output wave_1, output wave_2, output wave_3,
        output wave_4, output wave_5, output wave_6, output wave_7,
        input ready
    );
    modport sink (
        input valid, input record_id, input data_high, input data_low,
        input wave_0, input wave_1, input wave_2, input wave_3,
        input wave_4, input wave_5, input wave_6, input wave_7,
        output ready
    );
endinterface

>>> sv/framed_record_receiver.sv
// Top level: framed record receiver with registered record output.
// Throughput: one byte per cycle; ready drops only while a finished record waits unclaimed.
// A record is offered in the cycle after the transfer of its end byte.
// The output register frees in the same cycle it is drained, so bytes keep flowing.
// Reset (rst_n low, async): parser hunts for a start byte, sum and id clear, no record held.
// Held frame bytes are not reset; each is rewritten before a record can use it.
`timescale 1ns / 1ps

module framed_record_receiver (
    input  logic                clk,
    input  logic                rst_n,
    frr_byte_if.sink            in_ch,
    frr_record_if.source        out_ch
);
    import frr_pkg::*;

    logic        step;
    logic        emit;
    frr_record_t rec;

    logic        out_valid_reg;
    frr_record_t out_rec_reg;

    // A byte transfers whenever the output register is empty or being drained.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign step        = in_ch.valid && in_ch.ready;

    frr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_ch.rx_byte),
        .emit    (emit),
        .rec     (rec)
    );

    // Record output register. A good end byte loads it; the id comes from the
    // held state, which the end byte itself does not change.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && emit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
            out_rec_reg <= rec;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.record_id = out_rec_reg.record_id;
    assign out_ch.data_high = out_rec_reg.data_high;
    assign out_ch.data_low  = out_rec_reg.data_low;
    assign out_ch.wave_0    = out_rec_reg.wave_0;
    assign out_ch.wave_1    = out_rec_reg.wave_1;
    assign out_ch.wave_2    = out_rec_reg.wave_2;
    assign out_ch.wave_3    = out_rec_reg.wave_3;
    assign out_ch.wave_4    = out_rec_reg.wave_4;
    assign out_ch.wave_5    = out_rec_reg.wave_5;
    assign out_ch.wave_6    = out_rec_reg.wave_6;
    assign out_ch.wave_7    = out_rec_reg.wave_7;

endmodule

>>> sv/frr_parser.sv
// Frame parser: phase tracking, running checksum and held frame bytes.
`timescale 1ns / 1ps

module frr_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    output logic               emit,
    output frr_pkg::frr_record_t rec
);
    import frr_pkg::*;

    frr_phase_t              phase_reg, phase_next;
    logic [7:0]              sum_reg, sum_next;
    logic [5:0]              id_reg, id_next;
    logic [BODY_IDX_W-1:0]   idx_reg, idx_next;
    logic [7:0]              held_reg [BODY_LEN];

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        id_next    = id_reg;
        idx_next   = idx_reg;
        emit       = 1'b0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == START_BYTE)
                    phase_next = PH_SEQ;
                else
                    sum_next = 8'd0;
            end
            PH_SEQ:
            begin
                if (rx_byte <= MAX_ID)
                begin
                    id_next    = rx_byte[5:0];
                    sum_next   = sum_reg + rx_byte;
                    idx_next   = '0;
                    phase_next = PH_BODY;
                end
                else
                begin
                    sum_next   = 8'd0;
                    phase_next = PH_HUNT;
                end
            end
            PH_BODY:
            begin
                sum_next = sum_reg + rx_byte;
                if (idx_reg == BODY_IDX_W'(BODY_LEN - 1))
                    phase_next = PH_CHECK;
                else
                    idx_next = idx_reg + 1'b1;
            end
            PH_CHECK:
            begin
                sum_next = 8'd0;
                if (rx_byte == sum_reg)
                    phase_next = PH_END;
                else
                    phase_next = PH_HUNT;
            end
            PH_END:
            begin
                sum_next   = 8'd0;
                phase_next = PH_HUNT;
                emit       = (rx_byte == END_BYTE);
            end
            default:
            begin
                sum_next   = 8'd0;
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_reg   <= 8'd0;
            id_reg    <= 6'd0;
            idx_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            id_reg    <= id_next;
            idx_reg   <= idx_next;
        end
    end

    // Body bytes: every slot is rewritten in each frame before it is emitted.
    always_ff @(posedge clk)
    begin
        if (step && phase_reg == PH_BODY)
            held_reg[idx_reg] <= rx_byte;
    end

    assign rec.record_id = id_reg;
    assign rec.data_high = held_reg[0];
    assign rec.data_low  = held_reg[1];
    assign rec.wave_0    = held_reg[2];
    assign rec.wave_1    = held_reg[3];
    assign rec.wave_2    = held_reg[4];
    assign rec.wave_3    = held_reg[5];
    assign rec.wave_4    = held_reg[6];
    assign rec.wave_5    = held_reg[7];
    assign rec.wave_6    = held_reg[8];
    assign rec.wave_7    = held_reg[9];

endmodule

>>> sv/frr_checker.sv
// Checker: port-level assertions for the framed record receiver, with bind.
`timescale 1ns / 1ps

module frr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] out_id,
    input logic [7:0] out_wave_7
);
    import frr_pkg::*;

    // Held record must not change while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(out_wave_7))
        else $error("record changed while stalled");

    // A new record only follows the transfer of an end byte.
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_byte == END_BYTE))
        else $error("record without end byte");

    // Empty output register never blocks input.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Emitted ids stay in range.
    a_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_id <= MAX_ID[5:0])
        else $error("record id out of range");

endmodule

bind framed_record_receiver frr_checker u_frr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.rx_byte),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_id     (out_ch.record_id),
    .out_wave_7 (out_ch.wave_7)
);
